FILE: hw/rtl/wcld_pkg.sv
package wcld_pkg;

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int ROW_W    = 12;
    localparam int ROWS     = 8;
    localparam int WHOUR_W  = 4;
    localparam int STEP_W   = 3;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [MINUTE_W-1:0] TO_LIMIT   = 6'd34;
    localparam logic [6:0]          TO_BASE    = 7'd64;
    localparam logic [HOUR_W-1:0]   HALF_DAY   = 5'd12;
    localparam logic [WHOUR_W-1:0]  NOON       = 4'd12;

    typedef logic [ROW_W-1:0] row_t;
    typedef row_t grid_t [ROWS];

    // cells that never light
    localparam row_t DASH0 = 12'h024;
    localparam row_t DASH1 = 12'h008;
    localparam row_t DASH2 = 12'h080;
    localparam row_t DASH3 = 12'h004;
    localparam row_t DASH4 = 12'h000;
    localparam row_t DASH5 = 12'h800;
    localparam row_t DASH6 = 12'h800;
    localparam row_t DASH7 = 12'h07F;

    // "it is" letters in row 0
    localparam row_t IT_IS = 12'h01B;

    typedef enum logic [1:0] {
        DIR_PAST = 2'd0,
        DIR_TO   = 2'd1,
        DIR_NONE = 2'd2
    } dir_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_0  = 3'd0,
        STEP_5  = 3'd1,
        STEP_10 = 3'd2,
        STEP_15 = 3'd3,
        STEP_20 = 3'd4,
        STEP_25 = 3'd5,
        STEP_30 = 3'd6
    } step_t;

endpackage

FILE: hw/rtl/wcld_if.sv
interface wcld_time_if;
    import wcld_pkg::*;

    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   hour_of_day;
    logic [MINUTE_W-1:0] minute_of_hour;

    modport source (output valid, output hour_of_day, output minute_of_hour, input ready);
    modport sink (input valid, input hour_of_day, input minute_of_hour, output ready);
endinterface

interface wcld_grid_if;
    import wcld_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row0_lit;
    logic [ROW_W-1:0] row1_lit;
    logic [ROW_W-1:0] row2_lit;
    logic [ROW_W-1:0] row3_lit;
    logic [ROW_W-1:0] row4_lit;
    logic [ROW_W-1:0] row5_lit;
    logic [ROW_W-1:0] row6_lit;
    logic [ROW_W-1:0] row7_lit;
    logic             words_changed;

    modport source (
        output valid, output row0_lit, output row1_lit, output row2_lit, output row3_lit,
        output row4_lit, output row5_lit, output row6_lit, output row7_lit,
        output words_changed, input ready
    );
    modport sink (
        input valid, input row0_lit, input row1_lit, input row2_lit, input row3_lit,
        input row4_lit, input row5_lit, input row6_lit, input row7_lit,
        input words_changed, output ready
    );
endinterface

FILE: hw/rtl/word_clock_letter_decoder.sv
// channel    | dir | payload                              | handshake
// in_time    | in  | hour_of_day[4:0], minute_of_hour[5:0] | valid/ready
// out_grid   | out | row0_lit..row7_lit[11:0], words_changed | valid/ready
// cfg        | in  | cfg_write_data (article off)          | cfg_write_en
//
// an accepted beat reaches its result beat through the input register, then the result register
// one beat per cycle sustained while out_grid.ready is high; decode is a single pass between the two registers
// rst_n clears the valid flags, the article-off flag and the previous word time
// a stalled result holds; the input register still takes a beat whenever it drains
// in the same cycle, so in_time.ready follows out_grid.ready combinationally
module word_clock_letter_decoder (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write_en,
    input  logic cfg_write_data,
    wcld_time_if.sink   in_time,
    wcld_grid_if.source out_grid
);
    import wcld_pkg::*;

    logic                s1_valid_reg;
    logic [HOUR_W-1:0]   s1_hour_reg;
    logic [MINUTE_W-1:0] s1_minute_reg;
    logic                out_valid_reg;
    grid_t               out_rows_reg;
    logic                out_changed_reg;
    logic                article_off_reg;
    logic [WHOUR_W-1:0]  prior_hour_reg;
    step_t               prior_step_reg;
    dir_t                prior_dir_reg;

    logic                advance;
    logic                in_fire;

    logic [HOUR_W-1:0]   h;
    logic [MINUTE_W-1:0] m;
    logic [WHOUR_W-1:0]  hr_next;
    logic [MINUTE_W-1:0] val;
    step_t               step_next;
    dir_t                dir_next;
    grid_t               rows_next;
    logic                changed_next;

    logic [12:1] hs;
    logic m5, m10, m15, m20, m25, m30, past, to;

    assign advance      = s1_valid_reg && (!out_valid_reg || out_grid.ready);
    assign in_time.ready = !s1_valid_reg || advance;
    assign in_fire      = in_time.valid && in_time.ready;

    // word time
    always_comb
    begin
        logic [WHOUR_W-1:0] hr12;
        h = (s1_hour_reg > HOUR_MAX) ? HOUR_MAX : s1_hour_reg;
        m = (s1_minute_reg > MINUTE_MAX) ? MINUTE_MAX : s1_minute_reg;
        if (h == '0)
        begin
            hr12 = NOON;
        end
        else if (h > HALF_DAY)
        begin
            hr12 = WHOUR_W'(h - HALF_DAY);
        end
        else
        begin
            hr12 = h[WHOUR_W-1:0];
        end
        if (m > TO_LIMIT)
        begin
            dir_next = DIR_TO;
            val      = MINUTE_W'(TO_BASE - {1'b0, m});
            hr_next  = (hr12 == NOON) ? WHOUR_W'(1) : hr12 + WHOUR_W'(1);
        end
        else
        begin
            dir_next = DIR_PAST;
            val      = m;
            hr_next  = hr12;
        end
        // snap down to a five-minute step, at most half past
        if (val >= MINUTE_W'(30))      step_next = STEP_30;
        else if (val >= MINUTE_W'(25)) step_next = STEP_25;
        else if (val >= MINUTE_W'(20)) step_next = STEP_20;
        else if (val >= MINUTE_W'(15)) step_next = STEP_15;
        else if (val >= MINUTE_W'(10)) step_next = STEP_10;
        else if (val >= MINUTE_W'(5))  step_next = STEP_5;
        else                           step_next = STEP_0;
        if (step_next == STEP_0)
        begin
            dir_next = DIR_NONE;
        end
    end

    // letter grid: each run of cells between marks shares one condition
    always_comb
    begin
        for (int k = 1; k <= 12; k++)
        begin
            hs[k] = (hr_next == WHOUR_W'(k));
        end
        m5   = (step_next == STEP_5);
        m10  = (step_next == STEP_10);
        m15  = (step_next == STEP_15);
        m20  = (step_next == STEP_20);
        m25  = (step_next == STEP_25);
        m30  = (step_next == STEP_30);
        past = (dir_next == DIR_PAST);
        to   = (dir_next == DIR_TO);

        rows_next[0] = {{6{m20 | m25}}, 6'b111111} & ~DASH0;
        rows_next[1] = {m15 & ~article_off_reg, {3{m5 | m25}}, m30 | m5 | m25,
                        {3{m30}}, {4{m10}}} & ~DASH1;
        rows_next[2] = {{4{past}}, {8{m15}}} & ~DASH2;
        rows_next[3] = {{4{hs[4]}}, {2{hs[1]}}, hs[2] | hs[1], {2{hs[2]}}, {3{to}}} & ~DASH3;
        rows_next[4] = {{3{hs[6]}}, {4{hs[3]}}, hs[8] | hs[3], {4{hs[8]}}} & ~DASH4;
        rows_next[5] = {{6{hs[11]}}, hs[12] | hs[11], {5{hs[12]}}} & ~DASH5;
        rows_next[6] = {{4{hs[10]}}, {4{hs[9]}}, {4{hs[5]}}} & ~DASH6;
        rows_next[7] = {{5{hs[7]}}, {7{hs[10]}}} & ~DASH7;

        changed_next = (hr_next != prior_hour_reg) || (step_next != prior_step_reg)
                       || (dir_next != prior_dir_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            article_off_reg  <= 1'b0;
            prior_hour_reg   <= '0;
            prior_step_reg   <= STEP_0;
            prior_dir_reg    <= DIR_PAST;
        end
        else
        begin
            if (cfg_write_en)
            begin
                article_off_reg <= cfg_write_data;
            end
            if (in_time.ready)
            begin
                s1_valid_reg <= in_time.valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                prior_hour_reg <= hr_next;
                prior_step_reg <= step_next;
                prior_dir_reg  <= dir_next;
            end
            else if (out_grid.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_hour_reg   <= in_time.hour_of_day;
            s1_minute_reg <= in_time.minute_of_hour;
        end
        if (advance)
        begin
            out_rows_reg    <= rows_next;
            out_changed_reg <= changed_next;
        end
    end

    assign out_grid.valid         = out_valid_reg;
    assign out_grid.row0_lit      = out_rows_reg[0];
    assign out_grid.row1_lit      = out_rows_reg[1];
    assign out_grid.row2_lit      = out_rows_reg[2];
    assign out_grid.row3_lit      = out_rows_reg[3];
    assign out_grid.row4_lit      = out_rows_reg[4];
    assign out_grid.row5_lit      = out_rows_reg[5];
    assign out_grid.row6_lit      = out_rows_reg[6];
    assign out_grid.row7_lit      = out_rows_reg[7];
    assign out_grid.words_changed = out_changed_reg;

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded beat did not reach the result register");

    a_past_to_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_rows_reg[2][8] && out_rows_reg[3][0]))
        else $error("past and to lit together");

    a_it_is_lit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_rows_reg[0] & IT_IS) == IT_IS))
        else $error("it is not lit");

    a_dash_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_rows_reg[7] & DASH7) == '0 && (out_rows_reg[5] & DASH5) == '0))
        else $error("dash cell lit");

endmodule
